/* src/mirb_pkg.sv */
// Shared types and codes for the masked insert/remove character buffer.
`default_nettype none
package mirb_pkg;

  // Action codes carried by an input word.
  typedef enum logic [2:0] {
    ActRead   = 3'd0,
    ActWrite  = 3'd1,
    ActInsert = 3'd2,
    ActRemove = 3'd3,
    ActClear  = 3'd4
  } act_e;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CellHold      = 2'd0,
    CellWrite     = 2'd1,
    CellShiftUp   = 2'd2,
    CellShiftDown = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [7:0]  pos;
    logic [7:0]  wdata;  // already masked
  } cell_ctrl_t;

  localparam int unsigned CharW = 8;
  localparam int unsigned LenW  = 9;
  localparam int unsigned IdxCmpW = 16;  // wide enough for any cell index

endpackage
`default_nettype wire

/* src/masked_insert_remove_char_buffer.sv */
// Top level of the masked insert/remove character buffer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  command  | start_i / busy_o     | action_i, position_i, char_in_i
//  result   | done_o (one cycle)   | char_out_o, cur_length_o, status_o
//  config   | mask_we_i            | mask_wdata_i
//
// Each word passes through StGather, where the group register of the read tree over
// the cell row samples, and StReduce, where the result register is loaded for done_o.
// A new word may be started in the cycle done_o is high.
// Reset clears control state and the length and sets the mask to 1;
// cell contents are undefined until written. done_o cannot be stalled.
`default_nettype none
module masked_insert_remove_char_buffer
  import mirb_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [2:0]       action_i,
  input  wire logic [7:0]       position_i,
  input  wire logic [7:0]       char_in_i,
  output logic                  done_o,
  output logic      [CharW-1:0] char_out_o,
  output logic      [LenW-1:0]  cur_length_o,
  output logic                  status_o,
  input  wire logic             mask_we_i,
  input  wire logic [7:0]       mask_wdata_i
);

  localparam int unsigned FillW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StGather,
    StReduce
  } state_e;

  state_e           state_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       mask_q;
  act_e             act_q;
  logic [7:0]       pos_q;
  logic [7:0]       wdata_q;
  logic             ok_q, ok_d;
  logic             done_q, status_q;
  logic [CharW-1:0] char_q;
  logic [LenW-1:0]  len_q;
  logic             accept;
  logic             full;
  logic             pos_lt, pos_le;
  cell_ctrl_t       ctrl;
  logic [CharW-1:0] cell_data [DEPTH];
  logic [CharW-1:0] cell_read [DEPTH];
  logic [CharW-1:0] tree_data;

  assign accept = start_i && (state_q == StIdle);
  assign full   = (fill_q == FillW'(DEPTH));
  assign pos_lt = (32'(position_i) < 32'(fill_q));
  assign pos_le = (32'(position_i) <= 32'(fill_q));

  always_comb begin
    unique case (action_i)
      ActRead, ActWrite, ActRemove: ok_d = pos_lt;
      ActInsert:                    ok_d = pos_le && !full;
      ActClear:                     ok_d = 1'b1;
      default:                      ok_d = 1'b0;
    endcase
  end

  // cells change only on the last cycle, after the read tree has sampled
  always_comb begin
    ctrl.pos   = pos_q;
    ctrl.wdata = wdata_q;
    ctrl.op    = CellHold;
    if (state_q == StReduce && ok_q) begin
      unique case (act_q)
        ActWrite:  ctrl.op = CellWrite;
        ActInsert: ctrl.op = CellShiftUp;
        ActRemove: ctrl.op = CellShiftDown;
        default:   ctrl.op = CellHold;
      endcase
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ok_q) begin
      unique case (act_q)
        ActInsert: fill_d = fill_q + FillW'(1);
        ActRemove: fill_d = fill_q - FillW'(1);
        ActClear:  fill_d = '0;
        default:   fill_d = fill_q;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CharW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    mirb_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .read_o  (cell_read[i])
    );
  end

  mirb_read_tree #(
    .DEPTH (DEPTH),
    .GROUP (16)
  ) u_tree (
    .clk_i  (clk_i),
    .read_i (cell_read),
    .data_o (tree_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      mask_q  <= 8'h01;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (mask_we_i) mask_q <= mask_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            ok_q    <= ok_d;
            state_q <= StGather;
          end
        end
        StGather: state_q <= StReduce;
        StReduce: begin
          fill_q  <= fill_d;
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= act_e'(action_i);
      pos_q   <= position_i;
      wdata_q <= char_in_i ^ mask_q;
    end
    if (state_q == StReduce) begin
      status_q <= !ok_q;
      len_q    <= LenW'(fill_d);
      char_q   <= (ok_q && (act_q == ActRead || act_q == ActRemove)) ?
                  (tree_data ^ mask_q) : '0;
    end
  end

  assign busy_o       = (state_q != StIdle);
  assign done_o       = done_q;
  assign char_out_o   = char_q;
  assign cur_length_o = len_q;
  assign status_o     = status_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_done_after_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StReduce))
    else $error("result strobe without a finished word");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted word did not occupy the block");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= DEPTH)
    else $error("length above depth");

endmodule
`default_nettype wire

/* src/mirb_cell.sv */
// One byte cell of the buffer row: write, shift up, shift down or hold.
`default_nettype none
module mirb_cell
  import mirb_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [CharW-1:0] left_i,
  input  wire logic [CharW-1:0] right_i,
  output logic      [CharW-1:0] data_o,
  output logic      [CharW-1:0] read_o
);

  localparam logic [IdxCmpW-1:0] MyIdx = IdxCmpW'(IDX);

  logic [CharW-1:0]   data_q, data_d;
  logic [IdxCmpW-1:0] pos_ext;
  logic               hit, above;

  assign pos_ext = {{(IdxCmpW-8){1'b0}}, ctrl_i.pos};
  assign hit     = (MyIdx == pos_ext);
  assign above   = (MyIdx > pos_ext);

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CellWrite: begin
        if (hit) data_d = ctrl_i.wdata;
      end
      CellShiftUp: begin
        if (above) data_d = left_i;
        else if (hit) data_d = ctrl_i.wdata;
      end
      CellShiftDown: begin
        if (above || hit) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign read_o = hit ? data_q : '0;

endmodule
`default_nettype wire

/* src/mirb_read_tree.sv */
// Registered OR tree that gathers the addressed cell's byte from the row.
`default_nettype none
module mirb_read_tree
  import mirb_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned GROUP = 16
) (
  input  wire logic             clk_i,
  input  wire logic [CharW-1:0] read_i [DEPTH],
  output logic      [CharW-1:0] data_o
);

  localparam int unsigned NGrp = (DEPTH + GROUP - 1) / GROUP;

  logic [CharW-1:0] grp_q [NGrp];
  logic [CharW-1:0] grp_d [NGrp];

  // at most one cell matches, so OR acts as the select
  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) grp_d[g] = grp_d[g] | read_i[g * GROUP + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGrp; g++) grp_q[g] <= grp_d[g];
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NGrp; g++) data_o = data_o | grp_q[g];
  end

endmodule
`default_nettype wire
